// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the calendar counter RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, suspended while reset is high.
`define CCT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CCT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/cct_pkg.sv -----
// Package for the calendar counter: time and date record, limits, reset values
// and the month length function. Has no dependencies.
`default_nettype none

package cct_pkg;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cct_time_type;

   localparam int unsigned TDATA_W = 40;
   localparam int unsigned FIELDS_W = 38;

   localparam logic [6:0] SEC_PER_MIN   = 7'd60;
   localparam logic [6:0] MIN_PER_HOUR  = 7'd60;
   localparam logic [5:0] HOUR_PER_DAY  = 6'd24;
   localparam logic [4:0] MONTH_PER_YR  = 5'd12;

   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;

   localparam logic [4:0] DAYS_SHORT    = 5'd30;
   localparam logic [4:0] DAYS_LONG     = 5'd31;
   localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [4:0] DAYS_FEB      = 5'd28;

   localparam cct_time_type TIME_RESET = '{
      year:   12'd2021,
      month:  4'd2,
      day:    5'd17,
      hour:   5'd12,
      minute: 6'd25,
      second: 6'd0
   };

   // Days in a month; any month code outside April, June, September,
   // November and February counts as a 31-day month.
   function automatic logic [4:0] month_length(input logic [3:0] month,
                                               input logic [1:0] year_low);
      logic [4:0] len;
      case (month)
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            len = DAYS_SHORT;
         end
         MONTH_FEB: begin
            len = (year_low == 2'd0) ? DAYS_FEB_LEAP : DAYS_FEB;
         end
         default: begin
            len = DAYS_LONG;
         end
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/calendar_clock_tick.sv -----
// Top level of the real-time calendar counter: input register, calendar state,
// result register and stream handshakes. Depends on cct_pkg, cct_step, assert_macros.svh.
//
// Usage:
// The req channel carries one item per one-second tick (req_tuser = 0) or per load
// of the whole time and date (req_tuser = 1, fields in req_tdata). The rsp channel
// returns one item for every request: the full time and date after the update.
// An accepted item is held in an input register; the calendar update is computed
// from it and written into both the calendar state and the result register, which
// drives rsp_tvalid, once the result register is empty or its item is being taken.
// Throughput is one item per cycle while rsp_tready stays high; the calendar state
// update is the only recurrence and it is computed combinationally.
// When rsp_tready is low the result register holds its item, the input register
// fills, and req_tready falls until the result is taken; no item is lost.
// Reset (synchronous, active high) empties both registers and sets the calendar to
// 12:25:00 on day 17 of month 2, year 2021.
`default_nettype none
`include "assert_macros.svh"

module calendar_clock_tick (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // load_second, load_minute, load_hour, load_day, load_month, load_year, zero pad
   input  logic [cct_pkg::TDATA_W-1:0] req_tdata,
   // command
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // seconds_now, minutes_now, hours_now, day_now, month_now, year_now, zero pad
   output logic [cct_pkg::TDATA_W-1:0] rsp_tdata
);
   import cct_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   logic         in_cmd_ff;
   cct_time_type in_load_ff;
   cct_time_type req_load;
   logic         out_valid_ff;
   logic         out_valid_in;
   cct_time_type out_time_ff;
   cct_time_type state_ff;
   cct_time_type state_in;
   logic         advance;
   logic         req_fire;

   assign req_load.second = req_tdata[5:0];
   assign req_load.minute = req_tdata[11:6];
   assign req_load.hour   = req_tdata[16:12];
   assign req_load.day    = req_tdata[21:17];
   assign req_load.month  = req_tdata[25:22];
   assign req_load.year   = req_tdata[37:26];

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   cct_step u_step (
      .now_time  (state_ff),
      .load_cmd  (in_cmd_ff),
      .load_time (in_load_ff),
      .next_time (state_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= TIME_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= req_tuser;
         in_load_ff <= req_load;
      end
      if (advance && in_valid_ff) begin
         out_time_ff <= state_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - FIELDS_W){1'b0}},
                        out_time_ff.year, out_time_ff.month, out_time_ff.day,
                        out_time_ff.hour, out_time_ff.minute, out_time_ff.second};

   `CCT_ASSERT(a_result_matches_state, clock, reset, out_valid_ff |-> out_time_ff == state_ff, "result register differs from calendar state")
   `CCT_ASSERT(a_load_stores_fields, clock, reset, (advance && in_valid_ff && in_cmd_ff) |=> state_ff == $past(in_load_ff), "load did not store the given time and date")
   `CCT_ASSERT(a_plain_tick, clock, reset, (advance && in_valid_ff && !in_cmd_ff && state_ff.second < 6'd58 && state_ff.minute < 6'd60 && state_ff.hour < 5'd24) |=> (state_ff.second == $past(state_ff.second) + 6'd1 && state_ff.minute == $past(state_ff.minute)), "tick without carry changed more than the seconds")
   `CCT_ASSERT_ALWAYS(a_reset_values, clock, reset |=> (state_ff == TIME_RESET && !out_valid_ff && !in_valid_ff), "reset did not restore the calendar")

endmodule

`default_nettype wire

// ----- hdl/cct_step.sv -----
// Next-state logic of the calendar counter: one second tick with carries, or a load.
// Purely combinational; depends on cct_pkg.
`default_nettype none

module cct_step (
   input  cct_pkg::cct_time_type now_time,
   input  logic                  load_cmd,
   input  cct_pkg::cct_time_type load_time,
   output cct_pkg::cct_time_type next_time
);
   import cct_pkg::*;

   logic [6:0]   sec_inc;
   logic         sec_wrap;
   logic [6:0]   min_inc;
   logic         min_wrap;
   logic [5:0]   hour_inc;
   logic         hour_wrap;
   logic [5:0]   day_inc;
   logic [4:0]   day_len;
   logic         day_wrap;
   logic [4:0]   month_inc;
   logic         month_wrap;
   cct_time_type tick_time;

   always_comb begin
      sec_inc   = {1'b0, now_time.second} + 7'd1;
      sec_wrap  = (sec_inc >= SEC_PER_MIN);

      min_inc   = {1'b0, now_time.minute} + {6'd0, sec_wrap};
      min_wrap  = (min_inc >= MIN_PER_HOUR);

      hour_inc  = {1'b0, now_time.hour} + {5'd0, min_wrap};
      hour_wrap = (hour_inc >= HOUR_PER_DAY);

      day_inc   = {1'b0, now_time.day} + {5'd0, hour_wrap};
      day_len   = month_length(now_time.month, now_time.year[1:0]);
      day_wrap  = (day_inc > {1'b0, day_len});

      month_inc  = {1'b0, now_time.month} + {4'd0, day_wrap};
      month_wrap = (month_inc > MONTH_PER_YR);

      tick_time.second = sec_wrap   ? 6'd0 : sec_inc[5:0];
      tick_time.minute = min_wrap   ? 6'd0 : min_inc[5:0];
      tick_time.hour   = hour_wrap  ? 5'd0 : hour_inc[4:0];
      tick_time.day    = day_wrap   ? 5'd1 : day_inc[4:0];
      tick_time.month  = month_wrap ? 4'd1 : month_inc[3:0];
      tick_time.year   = now_time.year + {11'd0, month_wrap};

      next_time = load_cmd ? load_time : tick_time;
   end

endmodule

`default_nettype wire
